[rtl/lfs_pkg.sv]
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants of the longest-job-first scheduler.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam int MAX_JOBS    = 8;
  localparam int IDX_W       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W       = $clog2(MAX_JOBS + 1);

  localparam int ARR_W       = 16;
  localparam int BUR_W       = 16;
  localparam int TIME_W      = 20;
  localparam int TOTAL_W     = 24;
  localparam int JOB_INDEX_W = 3;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
  } job_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] tat;
    logic [TOTAL_W-1:0] wt;
  } totals_t;

  typedef struct packed {
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
  } times_t;

endpackage

[rtl/lfs_calc.sv]
// ----------------------------------------------------------------------------
// lfs_calc
// Per-job turnaround and waiting times with clamping, and saturating totals.
// ----------------------------------------------------------------------------
module lfs_calc (
  input  lfs_pkg::job_t                 job,
  input  logic [lfs_pkg::TIME_W-1:0]    completion,
  input  lfs_pkg::totals_t              tot_in,
  output lfs_pkg::times_t               times,
  output lfs_pkg::totals_t              tot_out
);
  import lfs_pkg::*;

  logic [TIME_W-1:0]  arr_ext;
  logic [TIME_W-1:0]  bur_ext;
  logic [TOTAL_W:0]   tat_sum;
  logic [TOTAL_W:0]   wt_sum;

  always_comb begin
    arr_ext = TIME_W'(job.arrival);
    bur_ext = TIME_W'(job.burst);
    // clamp negative differences to zero
    times.tat = (completion >= arr_ext) ? (completion - arr_ext) : '0;
    times.wt  = (times.tat >= bur_ext) ? (times.tat - bur_ext) : '0;
    tat_sum   = {1'b0, tot_in.tat} + (TOTAL_W+1)'(times.tat);
    wt_sum    = {1'b0, tot_in.wt} + (TOTAL_W+1)'(times.wt);
    tot_out.tat = tat_sum[TOTAL_W] ? '1 : tat_sum[TOTAL_W-1:0];
    tot_out.wt  = wt_sum[TOTAL_W] ? '1 : wt_sum[TOTAL_W-1:0];
  end

endmodule

[rtl/longest_job_first_scheduler.sv]
// Sequencing: each selection round scans the loaded jobs one entry a cycle
//   and then commits its pick; a batch of n jobs needs at most
//   2n rounds, then emits one result per cycle while out_stall is low.
// Throughput: one batch at a time; in_stall is high from the final item until
//   the last result is loaded into the output register (one compare unit).
// Reset: synchronous active-low rst_n clears the job count, flags and time.
// ----------------------------------------------------------------------------
// longest_job_first_scheduler
// Non-preemptive longest-job-first scheduler over a batch of up to MAX_JOBS
// jobs, sequenced over one shared compare/add unit.
// ----------------------------------------------------------------------------
module longest_job_first_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lfs_pkg::ARR_W-1:0]         in_arrival_time,
  input  logic [lfs_pkg::BUR_W-1:0]         in_burst_time,
  input  logic                              in_final_job,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lfs_pkg::JOB_INDEX_W-1:0]   out_job_index,
  output logic [lfs_pkg::TIME_W-1:0]        out_completion_time,
  output logic [lfs_pkg::TIME_W-1:0]        out_turnaround_time,
  output logic [lfs_pkg::TIME_W-1:0]        out_waiting_time,
  output logic [lfs_pkg::TOTAL_W-1:0]       out_total_turnaround,
  output logic [lfs_pkg::TOTAL_W-1:0]       out_total_waiting,
  output logic                              out_final_result
);
  import lfs_pkg::*;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     jobs_r, jobs_nxt;
  logic [CNT_W-1:0]     done_r, done_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [TIME_W-1:0]    time_r, time_nxt;
  logic [MAX_JOBS-1:0]  fin_r, fin_nxt;
  logic                 pick_v_r, pick_v_nxt;
  logic [IDX_W-1:0]     pick_idx_r, pick_idx_nxt;
  job_t                 pick_r, pick_nxt;
  logic [ARR_W-1:0]     earliest_r, earliest_nxt;
  totals_t              tot_r, tot_nxt;
  logic                 out_valid_r, out_valid_nxt;

  job_t                 job_store_r [MAX_JOBS];
  logic [TIME_W-1:0]    cmp_store_r [MAX_JOBS];

  logic                 store_we;
  logic                 cmp_we;
  logic                 load_out;
  logic                 last_idx;
  logic                 better;
  logic [TIME_W:0]      time_sum;
  logic [TIME_W-1:0]    time_sat;
  job_t                 cur_job;
  logic [TIME_W-1:0]    cur_cmp;
  times_t               cur_times;
  totals_t              calc_tot;

  logic [JOB_INDEX_W-1:0] out_job_index_r;
  logic [TIME_W-1:0]      out_completion_r;
  logic [TIME_W-1:0]      out_turnaround_r;
  logic [TIME_W-1:0]      out_waiting_r;
  logic [TOTAL_W-1:0]     out_total_tat_r;
  logic [TOTAL_W-1:0]     out_total_wt_r;
  logic                   out_final_r;

  assign cur_job  = job_store_r[idx_r];
  assign cur_cmp  = cmp_store_r[idx_r];
  assign last_idx = ((CNT_W'(idx_r) + CNT_W'(1)) == jobs_r);
  assign time_sum = {1'b0, time_r} + (TIME_W+1)'(pick_r.burst);
  assign time_sat = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
  assign better   = !pick_v_r || (cur_job.burst > pick_r.burst) ||
                    ((cur_job.burst == pick_r.burst) && (cur_job.arrival < pick_r.arrival));

  lfs_calc u_calc (
    .job        (cur_job),
    .completion (cur_cmp),
    .tot_in     (tot_r),
    .times      (cur_times),
    .tot_out    (calc_tot)
  );

  always_comb begin
    state_nxt    = state_r;
    jobs_nxt     = jobs_r;
    done_nxt     = done_r;
    idx_nxt      = idx_r;
    time_nxt     = time_r;
    fin_nxt      = fin_r;
    pick_v_nxt   = pick_v_r;
    pick_idx_nxt = pick_idx_r;
    pick_nxt     = pick_r;
    earliest_nxt = earliest_r;
    tot_nxt      = tot_r;
    store_we     = 1'b0;
    cmp_we       = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (jobs_r < CNT_W'(MAX_JOBS)) begin
            store_we = 1'b1;
            jobs_nxt = jobs_r + CNT_W'(1);
          end
          if (in_final_job) begin
            state_nxt    = ST_SCAN;
            idx_nxt      = '0;
            done_nxt     = '0;
            time_nxt     = '0;
            pick_v_nxt   = 1'b0;
            earliest_nxt = '1;
          end
        end
      end
      ST_SCAN: begin
        if (!fin_r[idx_r]) begin
          if (cur_job.arrival < earliest_r) begin
            earliest_nxt = cur_job.arrival;
          end
          if ((TIME_W'(cur_job.arrival) <= time_r) && better) begin
            pick_v_nxt   = 1'b1;
            pick_idx_nxt = idx_r;
            pick_nxt     = cur_job;
          end
        end
        if (last_idx) begin
          state_nxt = ST_COMMIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_COMMIT: begin
        idx_nxt      = '0;
        pick_v_nxt   = 1'b0;
        earliest_nxt = '1;
        state_nxt    = ST_SCAN;
        if (pick_v_r) begin
          time_nxt            = time_sat;
          cmp_we              = 1'b1;
          fin_nxt[pick_idx_r] = 1'b1;
          done_nxt            = done_r + CNT_W'(1);
          if ((done_r + CNT_W'(1)) == jobs_r) begin
            state_nxt = ST_EMIT;
            tot_nxt   = '0;
          end
        end else begin
          time_nxt = TIME_W'(earliest_r);
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          load_out = 1'b1;
          tot_nxt  = calc_tot;
          if (last_idx) begin
            state_nxt = ST_LOAD;
            jobs_nxt  = '0;
            fin_nxt   = '0;
            time_nxt  = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      jobs_r      <= '0;
      done_r      <= '0;
      idx_r       <= '0;
      time_r      <= '0;
      fin_r       <= '0;
      pick_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      jobs_r      <= jobs_nxt;
      done_r      <= done_nxt;
      idx_r       <= idx_nxt;
      time_r      <= time_nxt;
      fin_r       <= fin_nxt;
      pick_v_r    <= pick_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pick_idx_r <= pick_idx_nxt;
    pick_r     <= pick_nxt;
    earliest_r <= earliest_nxt;
    tot_r      <= tot_nxt;
    if (store_we) begin
      job_store_r[jobs_r[IDX_W-1:0]] <= '{arrival: in_arrival_time, burst: in_burst_time};
    end
    if (cmp_we) begin
      cmp_store_r[pick_idx_r] <= time_sat;
    end
    if (load_out) begin
      out_job_index_r  <= JOB_INDEX_W'(idx_r);
      out_completion_r <= cur_cmp;
      out_turnaround_r <= cur_times.tat;
      out_waiting_r    <= cur_times.wt;
      out_total_tat_r  <= last_idx ? calc_tot.tat : '0;
      out_total_wt_r   <= last_idx ? calc_tot.wt : '0;
      out_final_r      <= last_idx;
    end
  end

  assign in_stall             = (state_r != ST_LOAD);
  assign out_valid            = out_valid_r;
  assign out_job_index        = out_job_index_r;
  assign out_completion_time  = out_completion_r;
  assign out_turnaround_time  = out_turnaround_r;
  assign out_waiting_time     = out_waiting_r;
  assign out_total_turnaround = out_total_tat_r;
  assign out_total_waiting    = out_total_wt_r;
  assign out_final_result     = out_final_r;

`ifndef SYNTHESIS
  a_jobs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    jobs_r <= CNT_W'(MAX_JOBS))
    else $error("job count above capacity");

  a_pick_unfinished: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT && pick_v_r) |-> !fin_r[pick_idx_r])
    else $error("picked a finished job");

  a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (done_r < jobs_r))
    else $error("scan with no pending job");

  a_batch_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && load_out && last_idx) |=>
      (state_r == ST_LOAD && jobs_r == '0 && fin_r == '0 && out_final_result))
    else $error("batch did not close after final item");
`endif

endmodule
